/* hdl/rmq_pkg.sv */
// ----------------------------------------------------------------------------
// rmq_pkg
// Shared widths, payload types and arithmetic step functions for the
// rotation matrix to quaternion unit.
// ----------------------------------------------------------------------------
package rmq_pkg;

    localparam int DW     = 32;            // element width, signed Q2.(DW-2)
    localparam int FB     = DW - 2;        // fraction bits
    localparam int TW     = DW + 2;        // trace combination width
    localparam int RW     = DW + 3;        // radicand (1 + trace) width
    localparam int SW     = DW + 1;        // off-diagonal sum width
    localparam int MW     = SW;            // magnitude of an off-diagonal sum
    localparam int XW     = 2 * DW;        // square root operand width
    localparam int QRW    = DW + 2;        // square root partial remainder width
    localparam int NW     = MW + FB - 2;   // dividend width
    localparam int IN_W   = ((9 * DW + 7) / 8) * 8;
    localparam int OUT_W  = ((4 * DW + 2 + 7) / 8) * 8;
    localparam int QDEPTH = 2;
    localparam int QAW    = 1;

    typedef logic signed [SW-1:0] t_sval;

    typedef struct packed {
        logic [1:0]       pivot;
        logic [RW-1:0]    rad;
        t_sval [3:0]      s;       // s[0] scalar .. s[3] z, zero at the pivot
    } t_item;

    typedef struct packed {
        logic [1:0]       pivot;
        logic [DW-1:0]    q_z;
        logic [DW-1:0]    q_y;
        logic [DW-1:0]    q_x;
        logic [DW-1:0]    q_scalar;
    } t_result;

    typedef struct packed {
        logic [XW-1:0]    x;
        logic [QRW-1:0]   rem;
        logic [DW-1:0]    root;
    } t_sq;

    typedef struct packed {
        logic [DW-1:0]    rem;
        logic [DW-1:0]    lo;
        logic [DW-1:0]    q;
        logic             ovf;
    } t_dl;

    // One bit of a restoring integer square root.
    function automatic t_sq sq_step(t_sq a);
        logic [QRW-1:0] rem2;
        logic [QRW-1:0] trial;
        t_sq            r;
        rem2  = {a.rem[QRW-3:0], a.x[XW-1:XW-2]};
        trial = {a.root, 2'b01};
        r.x   = a.x << 2;
        if (rem2 >= trial) begin
            r.rem  = rem2 - trial;
            r.root = {a.root[DW-2:0], 1'b1};
        end else begin
            r.rem  = rem2;
            r.root = {a.root[DW-2:0], 1'b0};
        end
        return r;
    endfunction

    // One quotient bit of a restoring division by p.
    function automatic t_dl div_step(t_dl a, logic [DW-1:0] p);
        logic [DW:0] rem2;
        t_dl         r;
        rem2  = {a.rem, a.lo[DW-1]};
        r.lo  = a.lo << 1;
        r.ovf = a.ovf;
        if (rem2 >= {1'b0, p}) begin
            r.rem = DW'(rem2 - {1'b0, p});
            r.q   = {a.q[DW-2:0], 1'b1};
        end else begin
            r.rem = rem2[DW-1:0];
            r.q   = {a.q[DW-2:0], 1'b0};
        end
        return r;
    endfunction

    // Signed saturation of a sign and magnitude pair.
    function automatic logic [DW-1:0] sat(logic big, logic [DW-1:0] mag, logic neg);
        logic [DW-1:0] half;
        half = {1'b1, {(DW-1){1'b0}}};
        if (!neg) begin
            return (big || mag[DW-1]) ? {1'b0, {(DW-1){1'b1}}} : mag;
        end
        return (big || (mag > half)) ? half : DW'(~mag + 1'b1);
    endfunction

endpackage

/* hdl/rmq_front.sv */
// ----------------------------------------------------------------------------
// rmq_front
// Forms the trace combinations, picks the pivot and the matching
// off-diagonal sums, and builds the clamped radicand.
// ----------------------------------------------------------------------------
module rmq_front import rmq_pkg::*; (
    input  logic [IN_W-1:0] i_tdata,
    output t_item           o_item
);

    logic signed [DW-1:0] m [0:8];
    logic signed [TW-1:0] t [0:3];
    logic signed [TW-1:0] best;
    logic signed [RW-1:0] r;
    logic        [1:0]    n;
    t_sval                s01p, s01m, s20p, s20m, s12p, s12m;

    always_comb begin
        for (int k = 0; k < 9; k++) begin
            m[k] = $signed(i_tdata[k*DW +: DW]);
        end
    end

    assign t[0] = TW'(m[0]) + TW'(m[4]) + TW'(m[8]);
    assign t[1] = TW'(m[0]) - TW'(m[4]) - TW'(m[8]);
    assign t[2] = TW'(m[4]) - TW'(m[0]) - TW'(m[8]);
    assign t[3] = TW'(m[8]) - TW'(m[0]) - TW'(m[4]);

    // Strictly greater wins, so a tie keeps the lower index.
    always_comb begin
        n    = 2'd0;
        best = t[0];
        if (t[1] > best) begin
            n    = 2'd1;
            best = t[1];
        end
        if (t[2] > best) begin
            n    = 2'd2;
            best = t[2];
        end
        if (t[3] > best) begin
            n    = 2'd3;
            best = t[3];
        end
    end

    assign r = RW'(best) + (RW'(1) <<< FB);

    assign s12m = SW'(m[5]) - SW'(m[7]);
    assign s12p = SW'(m[5]) + SW'(m[7]);
    assign s20m = SW'(m[6]) - SW'(m[2]);
    assign s20p = SW'(m[6]) + SW'(m[2]);
    assign s01m = SW'(m[1]) - SW'(m[3]);
    assign s01p = SW'(m[1]) + SW'(m[3]);

    always_comb begin
        o_item.pivot = n;
        o_item.rad   = r[RW-1] ? '0 : r;
        o_item.s     = '0;
        case (n)
            2'd0: begin
                o_item.s[1] = s12m;
                o_item.s[2] = s20m;
                o_item.s[3] = s01m;
            end
            2'd1: begin
                o_item.s[0] = s12m;
                o_item.s[2] = s01p;
                o_item.s[3] = s20p;
            end
            2'd2: begin
                o_item.s[0] = s20m;
                o_item.s[1] = s01p;
                o_item.s[3] = s12p;
            end
            default: begin
                o_item.s[0] = s01m;
                o_item.s[1] = s20p;
                o_item.s[2] = s12p;
            end
        endcase
    end

endmodule

/* hdl/rmq_queue.sv */
// ----------------------------------------------------------------------------
// rmq_queue
// Two-entry queue that parts the classifying front from the arithmetic
// back end.
// ----------------------------------------------------------------------------
module rmq_queue import rmq_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_empty,
    output t_item o_head
);

    t_item          r_mem [0:QDEPTH-1];
    logic [QAW-1:0] r_wp, n_wp;
    logic [QAW-1:0] r_rp, n_rp;
    logic [QAW:0]   r_cnt, n_cnt;
    logic           wr, rd;

    assign o_full  = (r_cnt == (QAW+1)'(QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rp];
    assign wr      = i_push && !o_full;
    assign rd      = i_pop && !o_empty;

    always_comb begin
        n_wp  = wr ? r_wp + 1'b1 : r_wp;
        n_rp  = rd ? r_rp + 1'b1 : r_rp;
        n_cnt = r_cnt + (QAW+1)'(wr) - (QAW+1)'(rd);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wp] <= i_item;
        end
    end

endmodule

/* hdl/rmq_back.sv */
// ----------------------------------------------------------------------------
// rmq_back
// Pipelined square root, four pipelined dividers, sign fix and saturation.
// The whole pipeline moves in one step whenever the output register is
// free or being drained.
// ----------------------------------------------------------------------------
module rmq_back import rmq_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  t_item   i_item,
    output logic    o_pop,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_result
);

    logic          adv;
    logic [DW:0]   r_sv;
    t_sq           r_sq   [0:DW];
    logic [1:0]    r_spiv [0:DW];
    logic [3:0]    r_sneg [0:DW];
    logic [MW-1:0] r_smag [0:DW][0:3];
    logic [DW:0]   r_dv;
    logic [DW-1:0] r_dp   [0:DW];
    logic [1:0]    r_dpiv [0:DW];
    logic [3:0]    r_dneg [0:DW];
    t_dl           r_dl   [0:DW][0:3];
    logic          r_ov;
    t_result       r_res, n_res;
    t_sq           sq0;
    logic [NW-1:0] num  [0:3];
    logic [DW-1:0] hi   [0:3];
    logic [DW-1:0] fmag [0:3];
    logic [3:0]    fbig, fneg;
    logic          flip;
    logic [DW-1:0] fp;
    logic [1:0]    fpiv;

    assign adv      = !r_ov || i_ready;
    assign o_pop    = adv && i_valid;
    assign o_valid  = r_ov;
    assign o_result = r_res;

    assign sq0.x    = XW'(i_item.rad) << (FB - 2);
    assign sq0.rem  = '0;
    assign sq0.root = '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sv <= '0;
            r_dv <= '0;
            r_ov <= 1'b0;
        end else if (adv) begin
            r_sv <= {r_sv[DW-1:0], i_valid};
            r_dv <= {r_dv[DW-1:0], r_sv[DW]};
            r_ov <= r_dv[DW];
        end
    end

    // Square root pipeline, one result bit per stage.
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_sq[0]   <= sq0;
            r_spiv[0] <= i_item.pivot;
            for (int i = 0; i < 4; i++) begin
                r_sneg[0][i] <= i_item.s[i][SW-1];
                r_smag[0][i] <= i_item.s[i][SW-1] ? MW'(-i_item.s[i]) : MW'(i_item.s[i]);
            end
            for (int k = 0; k < DW; k++) begin
                r_sq[k+1]   <= sq_step(r_sq[k]);
                r_spiv[k+1] <= r_spiv[k];
                r_sneg[k+1] <= r_sneg[k];
                for (int i = 0; i < 4; i++) begin
                    r_smag[k+1][i] <= r_smag[k][i];
                end
            end
        end
    end

    // The high dividend bits decide at once whether the quotient needs
    // more than DW bits; only the low DW quotient bits are developed.
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            num[i] = NW'(r_smag[DW][i]) << (FB - 2);
            hi[i]  = DW'(num[i][NW-1:DW]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_dp[0]   <= r_sq[DW].root;
            r_dpiv[0] <= r_spiv[DW];
            r_dneg[0] <= r_sneg[DW];
            for (int i = 0; i < 4; i++) begin
                r_dl[0][i].rem <= hi[i];
                r_dl[0][i].lo  <= num[i][DW-1:0];
                r_dl[0][i].q   <= '0;
                r_dl[0][i].ovf <= (hi[i] >= r_sq[DW].root);
            end
            for (int k = 0; k < DW; k++) begin
                r_dp[k+1]   <= r_dp[k];
                r_dpiv[k+1] <= r_dpiv[k];
                r_dneg[k+1] <= r_dneg[k];
                for (int i = 0; i < 4; i++) begin
                    r_dl[k+1][i] <= div_step(r_dl[k][i], r_dp[k]);
                end
            end
        end
    end

    // Final assembly: pivot slot, zero pivot, sign fix and saturation.
    assign fp   = r_dp[DW];
    assign fpiv = r_dpiv[DW];
    assign flip = (fpiv != 2'd0) && (fp != '0) && r_dneg[DW][0]
               && (r_dl[DW][0].ovf || (r_dl[DW][0].q != '0));

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            if (fpiv == 2'(i)) begin
                fbig[i] = 1'b0;
                fmag[i] = fp;
                fneg[i] = flip;
            end else if (fp == '0) begin
                fbig[i] = 1'b0;
                fmag[i] = '0;
                fneg[i] = flip;
            end else begin
                fbig[i] = r_dl[DW][i].ovf;
                fmag[i] = r_dl[DW][i].q;
                fneg[i] = r_dneg[DW][i] ^ flip;
            end
        end
        n_res.q_scalar = sat(fbig[0], fmag[0], fneg[0]);
        n_res.q_x      = sat(fbig[1], fmag[1], fneg[1]);
        n_res.q_y      = sat(fbig[2], fmag[2], fneg[2]);
        n_res.q_z      = sat(fbig[3], fmag[3], fneg[3]);
        n_res.pivot    = fpiv;
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_res <= n_res;
        end
    end

endmodule

/* hdl/rotation_matrix_to_quaternion_unit.sv */
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion_unit
// Converts a 3x3 rotation matrix to a unit quaternion by Shepperd's method.
// ----------------------------------------------------------------------------
//  Channel   Direction  Contents (lowest bits first)
//  s_axis    in         m00 m01 m02 m10 m11 m12 m20 m21 m22
//  m_axis    out        q_scalar q_x q_y q_z pivot, zero fill
//
//  While m_axis tready holds high, one matrix is accepted per cycle and
//  one quaternion leaves per cycle. The back end has one square root
//  stage and one divider stage per result bit.
//  Reset clears only the queue and pipeline valid bits.
//  A stalled output freezes the back end; the two-entry queue still takes
//  input until it fills, then s_axis tready drops.
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion_unit import rmq_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    // m00, m01, m02, m10, m11, m12, m20, m21, m22 from bit 0 up
    input  logic [IN_W-1:0]  i_s_axis_tdata,
    output logic             o_m_axis_tvalid,
    input  logic             i_m_axis_tready,
    // q_scalar, q_x, q_y, q_z, pivot from bit 0 up, then zero fill
    output logic [OUT_W-1:0] o_m_axis_tdata
);

    t_item   front_item;
    t_item   head;
    t_result res;
    logic    q_full, q_empty, pop, push;

    // Front: classification of the matrix into pivot, radicand and sums.
    rmq_front u_front (
        .i_tdata (i_s_axis_tdata),
        .o_item  (front_item)
    );

    assign o_s_axis_tready = !q_full;
    assign push            = i_s_axis_tvalid && !q_full;

    rmq_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_empty (q_empty),
        .o_head  (head)
    );

    // Back: square root, division and final formatting.
    rmq_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (!q_empty),
        .i_item   (head),
        .o_pop    (pop),
        .o_valid  (o_m_axis_tvalid),
        .i_ready  (i_m_axis_tready),
        .o_result (res)
    );

    assign o_m_axis_tdata = OUT_W'({res.pivot, res.q_z, res.q_y, res.q_x, res.q_scalar});

endmodule

/* hdl/rmq_checker.sv */
// ----------------------------------------------------------------------------
// rmq_checker
// Port-level checks for the rotation matrix to quaternion unit.
// ----------------------------------------------------------------------------
module rmq_checker import rmq_pkg::*; (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             o_s_axis_tready,
    input logic             o_m_axis_tvalid,
    input logic             i_m_axis_tready,
    input logic [OUT_W-1:0] o_m_axis_tdata
);

    // A result waiting for transfer keeps its value.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("stalled result changed");

    // The sign fix leaves the scalar part non-negative.
    a_scalar: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> !o_m_axis_tdata[DW-1])
        else $error("negative scalar part");

    // Reset empties the pipeline.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid after reset");

    // Reset empties the queue, so input is taken right away.
    a_ready: assert property (@(posedge i_clk)
        !i_rst_n |=> o_s_axis_tready)
        else $error("input not ready after reset");

endmodule

bind rotation_matrix_to_quaternion_unit rmq_checker u_rmq_checker (.*);
